@@ rtl/ird_pkg.sv @@
// Shared types, constants and helpers for the IR pulse-width decoder.
`default_nettype none
package ird_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int FRAME_BITS  = 32;

    localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int STACK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int BIT_CNT_W   = $clog2(FRAME_BITS + 1);

    localparam int Q_DEPTH = 4;
    localparam int Q_IDX_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CMD_W    = 16;
    localparam int PERIOD_W = 8;
    localparam int REQ_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 8;

    localparam logic [CMD_W-1:0] REPEAT_CODE = 16'h00FF;

    // request codes
    localparam logic [REQ_W-1:0] REQ_EDGE    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH    = 3'd5;

    localparam logic [CFG_W-1:0] RST_REPEAT_LOW  = 8'hE2;
    localparam logic [CFG_W-1:0] RST_REPEAT_HIGH = 8'hE9;
    localparam logic [CFG_W-1:0] RST_START_LOW   = 8'h5D;
    localparam logic [CFG_W-1:0] RST_START_HIGH  = 8'h70;
    localparam logic [CFG_W-1:0] RST_ONE_LOW     = 8'h0F;
    localparam logic [CFG_W-1:0] RST_ONE_HIGH    = 8'h12;

    // one stack operation handed from the decoder to the stack
    typedef struct packed {
        logic             is_pop;
        logic [CMD_W-1:0] word;
    } t_op;

    function automatic logic in_window(input logic [PERIOD_W-1:0] p,
                                       input logic [CFG_W-1:0]    lo,
                                       input logic [CFG_W-1:0]    hi);
        in_window = (p >= lo) && (p <= hi);
    endfunction

endpackage
`default_nettype wire

@@ rtl/ird_front.sv @@
// Decoder front: configuration registers, pulse classification and frame assembly.
`default_nettype none
module ird_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [ird_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [ird_pkg::PERIOD_W-1:0]  i_period,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ird_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ird_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                               o_op_valid,
    input  wire logic                          i_op_ready,
    output ird_pkg::t_op                       o_op
);
    import ird_pkg::*;

    logic [CFG_W-1:0] r_repeat_low, r_repeat_high, r_start_low, r_start_high;
    logic [CFG_W-1:0] r_one_low, r_one_high;
    logic [BIT_CNT_W-1:0] r_bit_count, n_bit_count;
    logic [CMD_W-1:0]     r_shift, n_shift;
    logic                 accept;

    assign o_ready     = i_op_ready;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_low  <= RST_REPEAT_LOW;
            r_repeat_high <= RST_REPEAT_HIGH;
            r_start_low   <= RST_START_LOW;
            r_start_high  <= RST_START_HIGH;
            r_one_low     <= RST_ONE_LOW;
            r_one_high    <= RST_ONE_HIGH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REPEAT_LOW:  r_repeat_low  <= i_cfg_data;
                CFG_REPEAT_HIGH: r_repeat_high <= i_cfg_data;
                CFG_START_LOW:   r_start_low   <= i_cfg_data;
                CFG_START_HIGH:  r_start_high  <= i_cfg_data;
                CFG_ONE_LOW:     r_one_low     <= i_cfg_data;
                CFG_ONE_HIGH:    r_one_high    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        o_op_valid  = 1'b0;
        o_op        = '0;
        if (accept) begin
            case (i_req_type)
                REQ_EDGE: begin
                    if (r_bit_count == '0) begin
                        // idle: repeat window wins over start window
                        if (in_window(i_period, r_repeat_low, r_repeat_high)) begin
                            o_op_valid = 1'b1;
                            o_op.word  = REPEAT_CODE;
                        end else if (in_window(i_period, r_start_low, r_start_high)) begin
                            n_bit_count = BIT_CNT_W'(1);
                            n_shift     = '0;
                        end
                    end else begin
                        n_shift = {r_shift[CMD_W-2:0],
                                   in_window(i_period, r_one_low, r_one_high)};
                        if (r_bit_count >= BIT_CNT_W'(FRAME_BITS)) begin
                            o_op_valid  = 1'b1;
                            o_op.word   = n_shift;
                            n_bit_count = '0;
                        end else begin
                            n_bit_count = r_bit_count + BIT_CNT_W'(1);
                        end
                    end
                end
                REQ_TIMEOUT: n_bit_count = '0;
                REQ_POP: begin
                    o_op_valid  = 1'b1;
                    o_op.is_pop = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count <= '0;
            r_shift     <= '0;
        end else begin
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
        end
    end

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= BIT_CNT_W'(FRAME_BITS))
        else $error("bit counter ran past frame length");

    a_pop_forwarded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == REQ_POP) |-> (o_op_valid && o_op.is_pop))
        else $error("accepted pop not forwarded to the stack");

endmodule
`default_nettype wire

@@ rtl/ird_fifo.sv @@
// Short operation queue between the decoder front and the stack.
`default_nettype none
module ird_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr_valid,
    output logic              o_wr_ready,
    input  wire ird_pkg::t_op i_wr_op,
    output logic              o_rd_valid,
    input  wire logic         i_rd_ready,
    output ird_pkg::t_op      o_rd_op
);
    import ird_pkg::*;

    t_op                r_mem [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               wr_en, rd_en;

    assign o_wr_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_op    = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == Q_IDX_W'(Q_DEPTH - 1)) ? '0
                                                                 : r_wr_ptr + Q_IDX_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == Q_IDX_W'(Q_DEPTH - 1)) ? '0
                                                                 : r_rd_ptr + Q_IDX_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_count == $past(r_count) + Q_CNT_W'(1)))
        else $error("queue count missed a write");

endmodule
`default_nettype wire

@@ rtl/ird_back.sv @@
// Stack back end: command stack, push and pop execution, result register.
`default_nettype none
module ird_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_op_valid,
    output logic                           o_op_ready,
    input  wire ird_pkg::t_op              i_op,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [ird_pkg::CMD_W-1:0]      o_command,
    output logic                           o_stack_was_empty
);
    import ird_pkg::*;

    logic [CMD_W-1:0]       r_stack [STACK_DEPTH];
    logic [STACK_CNT_W-1:0] r_count;
    logic [STACK_CNT_W-1:0] top_cnt;
    logic [STACK_IDX_W-1:0] top_idx;
    logic                   r_out_valid;
    logic [CMD_W-1:0]       r_out_cmd;
    logic                   r_out_empty;
    logic                   take, do_push, do_pop, empty, full;

    // a pop needs room in the result register; a push never waits
    assign o_op_ready = !i_op.is_pop || !r_out_valid || i_ready;
    assign take       = i_op_valid && o_op_ready;
    assign empty      = (r_count == '0);
    assign full       = (r_count == STACK_CNT_W'(STACK_DEPTH));
    assign do_push    = take && !i_op.is_pop && !full;
    assign do_pop     = take && i_op.is_pop;
    assign top_cnt    = r_count - STACK_CNT_W'(1);
    assign top_idx    = top_cnt[STACK_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_stack[r_count[STACK_IDX_W-1:0]] <= i_op.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (do_push) begin
            r_count <= r_count + STACK_CNT_W'(1);
        end else if (do_pop && !empty) begin
            r_count <= top_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_out_cmd   <= empty ? '0 : r_stack[top_idx];
            r_out_empty <= empty;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_command         = r_out_cmd;
    assign o_stack_was_empty = r_out_empty;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= STACK_CNT_W'(STACK_DEPTH))
        else $error("stack count past depth");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stack_was_empty) |-> (o_command == '0))
        else $error("empty pop returned nonzero command");

endmodule
`default_nettype wire

@@ rtl/ir_pulse_width_decoder_stack_top.sv @@
// Top level of the IR pulse-width decoder with command stack.
// Accepts one item per cycle: edge periods, timeouts and pops. The front
// decodes periods against the repeat, start and one windows and assembles
// frames; pushes and pops pass through a four-entry operation queue to the
// stack, which holds up to 16 commands and drops pushes when full. A pop
// answer comes from the stack's result register once the pop has passed the queue;
// the input stalls only when the queue is full, which happens when pop
// answers sit unread at the output. Edge and timeout items give no result.
// Configuration writes are taken every cycle and must be made while idle.
`default_nettype none
module ir_pulse_width_decoder_stack_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [ird_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [ird_pkg::PERIOD_W-1:0]  i_period,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ird_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ird_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [ird_pkg::CMD_W-1:0]          o_command,
    output logic                               o_stack_was_empty
);
    import ird_pkg::*;

    logic f_valid, f_ready, b_valid, b_ready;
    t_op  f_op, b_op;

    ird_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_period    (i_period),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_op_valid  (f_valid),
        .i_op_ready  (f_ready),
        .o_op        (f_op)
    );

    ird_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_op    (f_op),
        .o_rd_valid (b_valid),
        .i_rd_ready (b_ready),
        .o_rd_op    (b_op)
    );

    ird_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op_valid        (b_valid),
        .o_op_ready        (b_ready),
        .i_op              (b_op),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_command         (o_command),
        .o_stack_was_empty (o_stack_was_empty)
    );

endmodule
`default_nettype wire
